FILE: sv/cfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants of the response frame checker
// Byte codes of the frame layout, register indexes and field widths.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CMDLEN_W = 2;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CMDLEN_W-1:0]  t_cmd_len;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Fixed frame overhead: two preamble bytes, two addresses, end byte.
    localparam t_pos FRAME_OVERHEAD = t_pos'(5);
    localparam t_pos POS_MAX        = {POS_W{1'b1}};

    localparam t_byte PREAMBLE_BYTE  = 8'hFE;
    localparam t_byte END_BYTE       = 8'hFD;
    localparam t_byte BROADCAST_ADDR = 8'h00;

    localparam t_cfg_idx REG_CONTROLLER_ADDR  = 3'd0;
    localparam t_cfg_idx REG_TRANSCEIVER_ADDR = 3'd1;
    localparam t_cfg_idx REG_COMMAND_LENGTH   = 3'd2;
    localparam t_cfg_idx REG_COMMAND_FIRST    = 3'd3;
    localparam t_cfg_idx REG_COMMAND_SECOND   = 3'd4;
    localparam t_cfg_idx REG_PAYLOAD_LENGTH   = 3'd5;

    localparam t_byte    RST_CONTROLLER_ADDR = 8'hE0;
    localparam t_cmd_len RST_COMMAND_LENGTH  = 2'd1;

endpackage
`default_nettype wire

FILE: sv/cfc_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfc channel interfaces
// Valid/ready channels of the frame checker: received bytes, results and
// register writes.
// ----------------------------------------------------------------------------
interface cfc_in_if;
    import cfc_pkg::*;
    logic  valid;
    logic  ready;
    t_byte frame_byte;
    logic  last_byte;
    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface cfc_out_if;
    logic valid;
    logic ready;
    logic frame_ok;
    modport source (output valid, frame_ok, input ready);
    modport sink   (input valid, frame_ok, output ready);
endinterface

interface cfc_cfg_if;
    import cfc_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_byte    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/civ_response_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// civ_response_frame_checker: remote-control response frame checker
// Checks received frame bytes against the expected response layout and
// gives one pass/fail item at the last byte of each frame.
// ----------------------------------------------------------------------------
// Takes one byte item per cycle; each byte is compared against the layout
// expected at its position (FE FE, controller or broadcast address,
// transceiver address, zero to two command bytes) and folded into a sticky
// pass flag, while a saturating 9-bit counter tracks the position. At the
// byte flagged last the end byte and the total length are checked and one
// result item is written to a two-entry output buffer; results are offered in
// order from its registered head entry. Bytes are accepted every
// cycle unless both output entries hold untaken results. Registers are
// written through the configuration channel at any time, which is always
// ready; a write takes effect for the bytes that follow it.
// ----------------------------------------------------------------------------
module civ_response_frame_checker (
    input  wire      i_clk,
    input  wire      i_rst_n,
    cfc_in_if.sink   i_byte_ch,
    cfc_out_if.source o_result_ch,
    cfc_cfg_if.sink  i_cfg_ch
);
    import cfc_pkg::*;

    // configuration registers
    t_byte    r_ctrl_addr;
    t_byte    r_xcvr_addr;
    t_cmd_len r_cmd_len;
    t_byte    r_cmd_first;
    t_byte    r_cmd_second;
    t_byte    r_payload_len;

    // frame state
    t_pos r_pos;
    logic r_still_valid;

    // output buffer: head entry and skid entry
    logic r_out_valid;
    logic r_out_ok;
    logic r_skid_valid;
    logic r_skid_ok;

    logic     accept;
    logic     pop;
    logic     push;
    t_cmd_len eff_cmd_len;
    logic     byte_ok;
    t_pos     expect_last_pos;
    logic     frame_ok;
    t_pos     n_pos;
    logic     n_still_valid;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_addr   <= RST_CONTROLLER_ADDR;
            r_xcvr_addr   <= '0;
            r_cmd_len     <= RST_COMMAND_LENGTH;
            r_cmd_first   <= '0;
            r_cmd_second  <= '0;
            r_payload_len <= '0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                REG_CONTROLLER_ADDR:  r_ctrl_addr   <= i_cfg_ch.data;
                REG_TRANSCEIVER_ADDR: r_xcvr_addr   <= i_cfg_ch.data;
                REG_COMMAND_LENGTH:   r_cmd_len     <= i_cfg_ch.data[CMDLEN_W-1:0];
                REG_COMMAND_FIRST:    r_cmd_first   <= i_cfg_ch.data;
                REG_COMMAND_SECOND:   r_cmd_second  <= i_cfg_ch.data;
                REG_PAYLOAD_LENGTH:   r_payload_len <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign accept = i_byte_ch.valid && i_byte_ch.ready;
    assign pop    = o_result_ch.valid && o_result_ch.ready;
    assign push   = accept && i_byte_ch.last_byte;

    // a length code of three counts as two
    assign eff_cmd_len = r_cmd_len[1] ? t_cmd_len'(2) : r_cmd_len;

    always_comb begin
        byte_ok = 1'b1;
        case (r_pos)
            t_pos'(0), t_pos'(1): byte_ok = (i_byte_ch.frame_byte == PREAMBLE_BYTE);
            t_pos'(2): byte_ok = (i_byte_ch.frame_byte == r_ctrl_addr)
                              || (i_byte_ch.frame_byte == BROADCAST_ADDR);
            t_pos'(3): byte_ok = (i_byte_ch.frame_byte == r_xcvr_addr);
            t_pos'(4): byte_ok = (eff_cmd_len == '0)
                              || (i_byte_ch.frame_byte == r_cmd_first);
            t_pos'(5): byte_ok = (eff_cmd_len != t_cmd_len'(2))
                              || (i_byte_ch.frame_byte == r_cmd_second);
            default:   byte_ok = 1'b1;
        endcase
    end

    // position of the last byte is one less than the expected length
    assign expect_last_pos = FRAME_OVERHEAD - t_pos'(1) + t_pos'(eff_cmd_len)
                           + t_pos'(r_payload_len);

    assign frame_ok = r_still_valid && byte_ok
                   && (i_byte_ch.frame_byte == END_BYTE)
                   && (r_pos == expect_last_pos);

    always_comb begin
        n_pos         = r_pos;
        n_still_valid = r_still_valid;
        if (accept) begin
            if (i_byte_ch.last_byte) begin
                n_pos         = '0;
                n_still_valid = 1'b1;
            end else begin
                n_still_valid = r_still_valid && byte_ok;
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + t_pos'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_still_valid <= 1'b1;
        end else begin
            r_pos         <= n_pos;
            r_still_valid <= n_still_valid;
        end
    end

    // hold new bytes only when both output entries are full
    assign i_byte_ch.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= push;
            end else begin
                r_out_valid  <= push;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_ok <= r_skid_ok;
                if (push) begin
                    r_skid_ok <= frame_ok;
                end
            end else if (push) begin
                r_out_ok <= frame_ok;
            end
        end else if (!r_out_valid) begin
            if (push) begin
                r_out_ok <= frame_ok;
            end
        end else if (push) begin
            r_skid_ok <= frame_ok;
        end
    end

    assign o_result_ch.valid    = r_out_valid;
    assign o_result_ch.frame_ok = r_out_ok;

`ifndef SYNTH
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the head entry is empty");

    a_result_buffered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_out_valid)
        else $error("result of a last byte was not buffered");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_byte_ch.last_byte && r_pos != POS_MAX)
        |=> (r_pos == $past(r_pos) + t_pos'(1)))
        else $error("byte position did not advance");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_pos == '0 && r_still_valid))
        else $error("frame state not cleared after last byte");
`endif

endmodule
`default_nettype wire

FILE: sim/civ_response_frame_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// civ_response_frame_checker_test: self-checking bench of the frame checker
// Feeds frames byte by byte, well-formed ones with random content as well as
// corrupted, resized, oversize and noise frames, under several register
// settings and idle patterns, and compares every pass/fail item with a
// predictor kept inside the bench or with a value pinned in a directed row.
// ----------------------------------------------------------------------------
module civ_response_frame_checker_test;
    import cfc_pkg::*;

    localparam int BYTES_TOTAL  = 1500;
    localparam int NUM_PHASES   = 9;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int OVERSIZE_LEN = 515;

    typedef struct {
        t_byte    ctrl_addr;
        t_byte    xcvr_addr;
        t_cmd_len cmd_len;
        t_byte    cmd_first;
        t_byte    cmd_second;
        t_byte    payload_len;
    } t_frame_regs;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_byte     val;
        logic      last;
        logic      pinned;
        logic      pinned_ok;
    } t_dir_row;

    localparam int N_DIR = 33;

    logic i_clk;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    cfc_in_if  byte_ch ();
    cfc_out_if res_ch ();
    cfc_cfg_if cfg_ch ();

    assign res_ch.ready = sink_ready;

    civ_response_frame_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (res_ch),
        .i_cfg_ch    (cfg_ch)
    );

    // Predictor state: register copy, position and sticky pass flag.
    t_frame_regs regs_shadow;
    t_pos        fr_pos;
    logic        fr_ok;

    logic verdict_q[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int n_bytes       = 0;
    int n_frames      = 0;
    int n_passed      = 0;
    int n_writes      = 0;
    int n_errs        = 0;
    int stall_cycles  = 0;

    // Short frames, broadcast address, command lengths zero and three,
    // extremes of bytes and a register write in the middle of a frame.
    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hE0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFD, 1'b1, 1'b1, 1'b1},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFD, 1'b1, 1'b1, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFD, 1'b1, 1'b1, 1'b1},
        '{ROW_REG,  REG_COMMAND_LENGTH,  8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hE0, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFD, 1'b1, 1'b1, 1'b1},
        '{ROW_REG,  REG_CONTROLLER_ADDR,  8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_REG,  REG_TRANSCEIVER_ADDR, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_REG,  REG_COMMAND_FIRST,    8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_REG,  REG_COMMAND_SECOND,   8'h01, 1'b0, 1'b0, 1'b0},
        '{ROW_REG,  REG_COMMAND_LENGTH,   8'h03, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFE, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFF, 1'b0, 1'b0, 1'b0},
        '{ROW_REG,  REG_PAYLOAD_LENGTH,  8'h01, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h01, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'h00, 1'b0, 1'b0, 1'b0},
        '{ROW_BYTE, REG_CONTROLLER_ADDR, 8'hFD, 1'b1, 1'b1, 1'b1}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        sink_ready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic int cmd_bytes_expected();
        return (regs_shadow.cmd_len > 2'd2) ? 2 : int'(regs_shadow.cmd_len);
    endfunction

    function automatic void shadow_write(input t_cfg_idx idx, input t_byte d);
        case (idx)
            REG_CONTROLLER_ADDR:  regs_shadow.ctrl_addr   = d;
            REG_TRANSCEIVER_ADDR: regs_shadow.xcvr_addr   = d;
            REG_COMMAND_LENGTH:   regs_shadow.cmd_len     = d[CMDLEN_W-1:0];
            REG_COMMAND_FIRST:    regs_shadow.cmd_first   = d;
            REG_COMMAND_SECOND:   regs_shadow.cmd_second  = d;
            REG_PAYLOAD_LENGTH:   regs_shadow.payload_len = d;
            default: ;
        endcase
    endfunction

    // Advance the frame state by one byte; returns 1 when a verdict is due.
    function automatic logic judge_byte(input t_byte b, input logic last, output logic ok);
        int   cmd_n;
        int   want_len;
        logic match;
        t_pos at;
        at    = fr_pos;
        cmd_n = cmd_bytes_expected();
        ok    = 1'b0;
        if (at < 2)
            match = (b == PREAMBLE_BYTE);
        else if (at == 2)
            match = (b == regs_shadow.ctrl_addr) || (b == BROADCAST_ADDR);
        else if (at == 3)
            match = (b == regs_shadow.xcvr_addr);
        else if (int'(at) < 4 + cmd_n)
            match = (b == ((at == 4) ? regs_shadow.cmd_first : regs_shadow.cmd_second));
        else
            match = 1'b1;
        if (!match)
            fr_ok = 1'b0;
        if (!last) begin
            if (fr_pos != POS_MAX)
                fr_pos = fr_pos + t_pos'(1);
            return 1'b0;
        end
        want_len = int'(FRAME_OVERHEAD) + cmd_n + int'(regs_shadow.payload_len);
        ok     = fr_ok && (b == END_BYTE) && (int'(at) + 1 == want_len);
        fr_pos = '0;
        fr_ok  = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_byte(input t_byte b, input logic last, input logic pinned,
                             input logic pinned_ok);
        logic ok;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.frame_byte <= b;
        byte_ch.last_byte  <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        n_bytes++;
        if (judge_byte(b, last, ok))
            verdict_q.push_back(pinned ? pinned_ok : ok);
    endtask

    // Hold the byte channel until every verdict has come and the block is quiet.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte d);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        shadow_write(idx, d);
        n_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic oversize);
        t_byte fq[$];
        int    kind;
        int    cmd_n;
        int    at;
        int    n;
        kind  = $urandom_range(99);
        cmd_n = cmd_bytes_expected();
        if (kind < 10 && !oversize) begin
            // noise: random bytes, random length
            n = $urandom_range(1, 12);
            repeat (n) fq.push_back(t_byte'($urandom));
        end else begin
            fq.push_back(PREAMBLE_BYTE);
            fq.push_back(PREAMBLE_BYTE);
            fq.push_back($urandom_range(1) ? regs_shadow.ctrl_addr : BROADCAST_ADDR);
            fq.push_back(regs_shadow.xcvr_addr);
            if (cmd_n > 0)
                fq.push_back(regs_shadow.cmd_first);
            if (cmd_n > 1)
                fq.push_back(regs_shadow.cmd_second);
            repeat (int'(regs_shadow.payload_len)) fq.push_back(t_byte'($urandom));
            fq.push_back(END_BYTE);
            if (oversize) begin
                while (fq.size() < OVERSIZE_LEN)
                    fq.insert(fq.size() - 1, t_byte'($urandom));
            end else if (kind < 25) begin
                at = $urandom_range(0, fq.size() - 1);
                fq[at] = fq[at] ^ t_byte'($urandom_range(1, 255));
            end else if (kind < 35) begin
                if ($urandom_range(1) && fq.size() > 1)
                    fq.delete($urandom_range(0, fq.size() - 2));
                else
                    fq.insert($urandom_range(0, fq.size() - 1), t_byte'($urandom));
            end
        end
        foreach (fq[i])
            send_byte(fq[i], i == fq.size() - 1, 1'b0, 1'b0);
        n_frames++;
    endtask

    // Result checker and stall watchdog.
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("frame_ok: no result expected, got %0b", res_ch.frame_ok);
                    n_errs++;
                end else begin
                    want = verdict_q.pop_front();
                    if (res_ch.frame_ok !== want) begin
                        $error("frame_ok: expected %0b, got %0b", want, res_ch.frame_ok);
                        n_errs++;
                    end
                end
                if (res_ch.frame_ok === 1'b1)
                    n_passed++;
            end
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("civ_response_frame_checker_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_byte    ca, ta, c1, c2, pl;
        t_cmd_len cl;
        int       in_phase;
        i_rst_n            <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.frame_byte <= '0;
        byte_ch.last_byte  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_CONTROLLER_ADDR;
        cfg_ch.data        <= '0;
        regs_shadow = '{RST_CONTROLLER_ADDR, 8'h00, RST_COMMAND_LENGTH, 8'h00, 8'h00, 8'h00};
        fr_pos = '0;
        fr_ok  = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_byte(dir_rows[r].val, dir_rows[r].last, dir_rows[r].pinned,
                          dir_rows[r].pinned_ok);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 3)
                0: begin src_idle_pct = 36; sink_idle_pct = 84; end
                1: begin src_idle_pct = 84; sink_idle_pct = 36; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            if (ph == 0) begin
                ca = 8'h00; ta = 8'h00; cl = 2'd0; c1 = 8'h00; c2 = 8'h00; pl = 8'h00;
            end else if (ph == 4) begin
                ca = 8'hFF; ta = 8'hFF; cl = 2'd3; c1 = 8'hFF; c2 = 8'hFF; pl = 8'hFF;
            end else begin
                ca = t_byte'($urandom);
                ta = t_byte'($urandom);
                cl = t_cmd_len'($urandom_range(3));
                c1 = t_byte'($urandom);
                c2 = t_byte'($urandom);
                pl = t_byte'($urandom_range(0, 8));
            end
            write_reg(REG_CONTROLLER_ADDR, ca);
            write_reg(REG_TRANSCEIVER_ADDR, ta);
            write_reg(REG_COMMAND_LENGTH, t_byte'(cl));
            write_reg(REG_COMMAND_FIRST, c1);
            write_reg(REG_COMMAND_SECOND, c2);
            write_reg(REG_PAYLOAD_LENGTH, pl);
            in_phase = 0;
            while (n_bytes < (ph + 1) * BYTES_TOTAL / NUM_PHASES || in_phase < 2) begin
                send_frame(ph == 7 && in_phase == 0);
                in_phase++;
                // hold off now and then until all verdicts are back
                if ($urandom_range(19) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $error("frame_ok: %0d results never arrived", verdict_q.size());
            n_errs++;
        end
        $display("covered %0d bytes in %0d frames, %0d judged good, %0d register writes",
                 n_bytes, n_frames + 5, n_passed, n_writes);
        $display("settings ranged over command lengths 0 to 3, payload 0 to 255, one oversize frame");
        if (n_errs == 0)
            $display("civ_response_frame_checker_test: done, clean");
        else
            $display("civ_response_frame_checker_test: done, errors");
        $finish;
    end

endmodule
